[design/first_fit_implicit_list_allocator_defines.svh]
// Assertion macros used by the allocator top module.
`ifndef FIRST_FIT_IMPLICIT_LIST_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_IMPLICIT_LIST_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define FFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("allocator check failed");
`define FFA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("allocator check failed");
`else
`define FFA_ASSERT(lbl, prop)
`define FFA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[design/ffa_pkg.sv]
package ffa_pkg;

  localparam int POS_W      = 16;
  localparam int HDR_W      = 16;
  localparam int REQ_W      = 16;
  localparam int REL_W      = 15;
  localparam int CFG_W      = 16;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 40;
  localparam int HDR_BYTES  = 8;
  localparam int SPLIT_MIN  = 16;
  localparam logic [CFG_W-1:0] MAX_REQ_RESET  = 16'h8000;
  localparam logic [CFG_W-1:0] HEAP_CFG_RESET = 16'h8000;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_LIMIT    = 3'd2,
    ST_NOFIT    = 3'd3,
    ST_NOTALLOC = 3'd4,
    ST_NOINIT   = 3'd5
  } status_t;

  typedef enum logic {
    REG_HEAP_BYTES  = 1'b0,
    REG_MAX_REQUEST = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0] next_pos;
    logic [POS_W-1:0] split_pos;
    logic [HDR_W-1:0] split_size;
    logic [HDR_W-1:0] size;
    logic [POS_W-1:0] blk_bytes;
    logic [POS_W-1:0] take_bytes;
    logic             is_free;
    logic             fit;
    logic             split;
    logic             hit;
  } walk_res_t;

endpackage

[design/first_fit_implicit_list_allocator.sv]
// Channel | Direction | Handshake               | Payload
// in      | input     | in_tvalid / in_tready   | in_tdata: operation, request_bytes,
//         |           |                         |   release_offset
// out     | output    | out_tvalid / out_tready | out_tdata: status, payload_offset,
//         |           |                         |   bytes_in_use
// cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Allocate and free walk the headers through one RAM read port: each header is read, then
// compared, between accepting the request and posting the result; a split adds a header
// write, and a walk that ends without a match adds a read. Other requests skip the walk.
// Synchronous active-low reset clears control state only; the header RAM is not cleared.
// A finished result waits in the output register for out_tready; the next request is
// taken meanwhile and stalls only when its own result is ready.
`include "first_fit_implicit_list_allocator_defines.svh"

module first_fit_implicit_list_allocator #(
  parameter int HEAP_BYTES = 32768
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [1:0] operation, [17:2] request_bytes, [32:18] release_offset, rest zero
  input  logic [ffa_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [2:0] status, [17:3] payload_offset, [33:18] bytes_in_use, rest zero
  output logic [ffa_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [ffa_pkg::CFG_W-1:0]   cfg_data
);
  import ffa_pkg::*;

  localparam int SLOTS = HEAP_BYTES / HDR_BYTES;
  localparam int SW    = $clog2(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SPLIT,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] heap_cfg_r, heap_cfg_nxt;
  logic [CFG_W-1:0] max_req_r, max_req_nxt;
  logic [POS_W-1:0] active_r, active_nxt;
  logic [POS_W-1:0] bytes_used_r, bytes_used_nxt;
  logic             ready_r, ready_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;

  logic             free_op_r, free_op_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] need_r, need_nxt;
  logic [POS_W-1:0] target_r, target_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [POS_W-1:0] res_off_r, res_off_nxt;
  logic [SW-1:0]    split_addr_r, split_addr_nxt;
  logic [HDR_W-1:0] split_val_r, split_val_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [REL_W-1:0] out_off_r, out_off_nxt;
  logic [POS_W-1:0] out_bytes_r, out_bytes_nxt;

  op_t              in_op;
  logic [REQ_W-1:0] in_req;
  logic [REL_W-1:0] in_rel;
  logic [REQ_W:0]   need_c;
  logic             over_limit;
  logic [CFG_W-1:0] heap_trim;
  logic [POS_W-1:0] active_c;
  logic             walk_on;

  logic             wr_en;
  logic [SW-1:0]    wr_addr;
  logic [HDR_W-1:0] wr_data;
  logic [HDR_W-1:0] rd_data;
  walk_res_t        walk;

  assign in_op  = op_t'(in_tdata[1:0]);
  assign in_req = in_tdata[17:2];
  assign in_rel = in_tdata[32:18];

  assign in_tready  = state_r == S_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_bytes_r, out_off_r, out_status_r};

  ffa_hdr_ram #(
    .SLOTS(SLOTS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(SW'(pos_r[POS_W-1:3])),
    .rd_data(rd_data)
  );

  ffa_walk_unit u_walk (
    .pos   (pos_r),
    .hdr   (rd_data),
    .need  (need_r),
    .target(target_r),
    .res   (walk)
  );

  always_comb begin
    need_c     = ({1'b0, in_req} + (REQ_W+1)'(7)) & ~(REQ_W+1)'(7);
    over_limit = (need_c > {1'b0, max_req_r}) ||
                 (({1'b0, need_c} + (REQ_W+2)'(bytes_used_r)) > (REQ_W+2)'(active_r));
    heap_trim  = {heap_cfg_r[CFG_W-1:3], 3'b000};
    if (heap_trim < CFG_W'(SPLIT_MIN)) begin
      active_c = POS_W'(SPLIT_MIN);
    end else if (32'(heap_trim) > 32'(HEAP_BYTES)) begin
      active_c = POS_W'(HEAP_BYTES);
    end else begin
      active_c = heap_trim;
    end
    walk_on = (pos_r < active_r) && (!free_op_r || (pos_r <= target_r));
  end

  always_comb begin
    state_nxt      = state_r;
    heap_cfg_nxt   = heap_cfg_r;
    max_req_nxt    = max_req_r;
    active_nxt     = active_r;
    bytes_used_nxt = bytes_used_r;
    ready_nxt      = ready_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    free_op_nxt    = free_op_r;
    pos_nxt        = pos_r;
    need_nxt       = need_r;
    target_nxt     = target_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    split_addr_nxt = split_addr_r;
    split_val_nxt  = split_val_r;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;
    out_bytes_nxt  = out_bytes_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_HEAP_BYTES:  heap_cfg_nxt = cfg_data;
        REG_MAX_REQUEST: max_req_nxt  = cfg_data;
        default:         heap_cfg_nxt = heap_cfg_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_off_nxt    = '0;
          res_status_nxt = ST_OK;
          pos_nxt        = '0;
          state_nxt      = S_DONE;
          case (in_op)
            OP_INIT: begin
              active_nxt     = active_c;
              bytes_used_nxt = '0;
              ready_nxt      = 1'b1;
              wr_en          = 1'b1;
              wr_data        = active_c - HDR_W'(HDR_BYTES);
            end
            OP_ALLOC: begin
              free_op_nxt = 1'b0;
              need_nxt    = need_c[POS_W-1:0];
              if (!ready_r) begin
                res_status_nxt = ST_NOINIT;
              end else if (in_req == '0) begin
                res_status_nxt = ST_ZERO;
              end else if (over_limit) begin
                res_status_nxt = ST_LIMIT;
              end else begin
                state_nxt = S_READ;
              end
            end
            OP_FREE: begin
              free_op_nxt = 1'b1;
              target_nxt  = POS_W'(in_rel) - POS_W'(HDR_BYTES);
              if (!ready_r) begin
                res_status_nxt = ST_NOINIT;
              end else if (in_rel == '0) begin
                res_status_nxt = ST_OK;
              end else if ((in_rel < REL_W'(HDR_BYTES)) || (in_rel[2:0] != 3'd0)) begin
                res_status_nxt = ST_NOTALLOC;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: res_status_nxt = ST_OK;
          endcase
        end
      end
      S_READ: begin
        if (walk_on) begin
          state_nxt = S_EVAL;
        end else begin
          res_status_nxt = free_op_r ? ST_NOTALLOC : ST_NOFIT;
          state_nxt      = S_DONE;
        end
      end
      S_EVAL: begin
        wr_addr = SW'(pos_r[POS_W-1:3]);
        if (!free_op_r) begin
          if (walk.fit) begin
            wr_en          = 1'b1;
            wr_data        = walk.split ? (need_r | HDR_W'(1)) : (walk.size | HDR_W'(1));
            bytes_used_nxt = bytes_used_r + walk.take_bytes;
            res_off_nxt    = pos_r + POS_W'(HDR_BYTES);
            res_status_nxt = ST_OK;
            split_addr_nxt = SW'(walk.split_pos[POS_W-1:3]);
            split_val_nxt  = walk.split_size;
            state_nxt      = walk.split ? S_SPLIT : S_DONE;
          end else begin
            pos_nxt   = walk.next_pos;
            state_nxt = S_READ;
          end
        end else begin
          if (walk.hit) begin
            state_nxt = S_DONE;
            if (walk.is_free) begin
              res_status_nxt = ST_NOTALLOC;
            end else begin
              wr_en          = 1'b1;
              wr_data        = walk.size;
              bytes_used_nxt = (bytes_used_r >= walk.blk_bytes) ?
                               bytes_used_r - walk.blk_bytes : '0;
              res_status_nxt = ST_OK;
            end
          end else begin
            pos_nxt   = walk.next_pos;
            state_nxt = S_READ;
          end
        end
      end
      S_SPLIT: begin
        wr_en     = 1'b1;
        wr_addr   = split_addr_r;
        wr_data   = split_val_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_off_nxt    = res_off_r[REL_W-1:0];
          out_bytes_nxt  = bytes_used_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    free_op_r    <= free_op_nxt;
    pos_r        <= pos_nxt;
    need_r       <= need_nxt;
    target_r     <= target_nxt;
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    split_addr_r <= split_addr_nxt;
    split_val_r  <= split_val_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
    out_bytes_r  <= out_bytes_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      heap_cfg_r   <= HEAP_CFG_RESET;
      max_req_r    <= MAX_REQ_RESET;
      active_r     <= '0;
      bytes_used_r <= '0;
      ready_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      heap_cfg_r   <= heap_cfg_nxt;
      max_req_r    <= max_req_nxt;
      active_r     <= active_nxt;
      bytes_used_r <= bytes_used_nxt;
      ready_r      <= ready_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  `FFA_ASSERT(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready)
  `FFA_ASSERT(a_usage_within_heap, bytes_used_r <= active_r)
  `FFA_ASSERT(a_split_after_eval, (state_r == S_SPLIT) |-> $past(state_r == S_EVAL))
  `FFA_ASSERT(a_ready_sticky, !$fell(ready_r))
  `FFA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE) && !out_tvalid_r)

endmodule

[design/ffa_hdr_ram.sv]
module ffa_hdr_ram #(
  parameter int SLOTS = 4096
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(SLOTS)-1:0]   wr_addr,
  input  logic [ffa_pkg::HDR_W-1:0]  wr_data,
  input  logic [$clog2(SLOTS)-1:0]   rd_addr,
  output logic [ffa_pkg::HDR_W-1:0]  rd_data
);
  import ffa_pkg::*;

  logic [HDR_W-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/ffa_walk_unit.sv]
module ffa_walk_unit (
  input  logic [ffa_pkg::POS_W-1:0] pos,
  input  logic [ffa_pkg::HDR_W-1:0] hdr,
  input  logic [ffa_pkg::POS_W-1:0] need,
  input  logic [ffa_pkg::POS_W-1:0] target,
  output ffa_pkg::walk_res_t        res
);
  import ffa_pkg::*;

  logic [HDR_W-1:0] size;
  logic [HDR_W-1:0] rem;

  always_comb begin
    size           = {hdr[HDR_W-1:1], 1'b0};
    rem            = size - need;
    res.size       = size;
    res.is_free    = ~hdr[0];
    res.fit        = ~hdr[0] && (need <= size);
    res.split      = rem >= HDR_W'(SPLIT_MIN);
    res.hit        = pos == target;
    res.next_pos   = pos + POS_W'(HDR_BYTES) + size;
    res.split_pos  = pos + POS_W'(HDR_BYTES) + need;
    res.split_size = rem - HDR_W'(HDR_BYTES);
    res.blk_bytes  = POS_W'(HDR_BYTES) + size;
    res.take_bytes = res.split ? POS_W'(HDR_BYTES) + need : POS_W'(HDR_BYTES) + size;
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ffa_pkg::*;

  localparam int HEAP_MAX     = 32768;
  localparam int SLOT_COUNT   = HEAP_MAX / HDR_BYTES;
  localparam int MIN_HEAP     = 16;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PRINT_LIMIT  = 40;

  typedef struct {
    status_t          status;
    logic [REL_W-1:0] payload;
    logic [15:0]      in_use;
  } alloc_resp_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // Allocator state as the testbench predicts it.
  logic [HDR_W-1:0] hdr_mem [SLOT_COUNT];
  int unsigned      used_bytes;
  int unsigned      heap_span;
  int unsigned      cfg_heap;
  int unsigned      cfg_max_req;
  bit               heap_up;
  int unsigned      live_payloads[$];
  alloc_resp_t      expected_resp[$];

  int          err_count = 0;
  int          sent_count = 0;
  int          checked_count = 0;
  int          cfg_writes = 0;
  int          status_seen [6];
  bit          tx_idle;
  bit          rx_idle;
  int unsigned cycle_count = 0;

  first_fit_implicit_list_allocator #(
    .HEAP_BYTES(HEAP_MAX)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= rx_idle ? ($urandom_range(99) >= 12) : 1'b1;
  end

  function automatic int unsigned slot_of(int unsigned off);
    return (off / HDR_BYTES) % SLOT_COUNT;
  endfunction

  function automatic status_t model_alloc(int unsigned req, output int unsigned off);
    int unsigned need;
    int unsigned pos;
    int unsigned hdr;
    int unsigned size;
    off = 0;
    if (!heap_up) return ST_NOINIT;
    if (req == 0) return ST_ZERO;
    need = (req + HDR_BYTES - 1) & ~(HDR_BYTES - 1);
    if (need > cfg_max_req || need + used_bytes > heap_span) return ST_LIMIT;
    pos = 0;
    while (pos < heap_span) begin
      hdr  = hdr_mem[slot_of(pos)];
      size = hdr & ~32'd1;
      if ((hdr & 1) == 0 && need <= size) begin
        if (size - need >= SPLIT_MIN) begin
          hdr_mem[slot_of(pos + HDR_BYTES + need)] = HDR_W'(size - need - HDR_BYTES);
          hdr_mem[slot_of(pos)] = HDR_W'(need | 1);
          used_bytes += HDR_BYTES + need;
        end else begin
          hdr_mem[slot_of(pos)] = HDR_W'(size | 1);
          used_bytes += HDR_BYTES + size;
        end
        off = pos + HDR_BYTES;
        return ST_OK;
      end
      pos += HDR_BYTES + size;
    end
    return ST_NOFIT;
  endfunction

  // The release is checked by walking the headers, so a block in the middle
  // of a payload or a free block is never touched.
  function automatic status_t model_free(int unsigned off);
    int unsigned target;
    int unsigned pos;
    int unsigned hdr;
    int unsigned size;
    if (!heap_up) return ST_NOINIT;
    if (off == 0) return ST_OK;
    if (off < HDR_BYTES || (off & (HDR_BYTES - 1)) != 0) return ST_NOTALLOC;
    target = off - HDR_BYTES;
    pos = 0;
    while (pos < heap_span && pos <= target) begin
      hdr  = hdr_mem[slot_of(pos)];
      size = hdr & ~32'd1;
      if (pos == target) begin
        if ((hdr & 1) == 0) return ST_NOTALLOC;
        hdr_mem[slot_of(pos)] = HDR_W'(size);
        if (used_bytes >= HDR_BYTES + size) used_bytes -= HDR_BYTES + size;
        else used_bytes = 0;
        return ST_OK;
      end
      pos += HDR_BYTES + size;
    end
    return ST_NOTALLOC;
  endfunction

  function automatic alloc_resp_t model_request(op_t op, logic [REQ_W-1:0] req,
                                                logic [REL_W-1:0] rel);
    alloc_resp_t resp;
    int unsigned off;
    off = 0;
    resp.status = ST_OK;
    case (op)
      OP_ALLOC: begin
        resp.status = model_alloc(int'(req), off);
        if (resp.status == ST_OK) live_payloads.push_back(off);
      end
      OP_FREE: begin
        resp.status = model_free(int'(rel));
        if (resp.status == ST_OK) begin
          foreach (live_payloads[i]) begin
            if (live_payloads[i] == rel) begin
              live_payloads.delete(i);
              break;
            end
          end
        end
      end
      OP_INIT: begin
        heap_span = cfg_heap & ~(HDR_BYTES - 1);
        if (heap_span < MIN_HEAP) heap_span = MIN_HEAP;
        if (heap_span > HEAP_MAX) heap_span = HEAP_MAX;
        hdr_mem[0] = HDR_W'(heap_span - HDR_BYTES);
        used_bytes = 0;
        heap_up = 1'b1;
        live_payloads.delete();
      end
      default: begin
      end
    endcase
    resp.payload = off[REL_W-1:0];
    resp.in_use  = used_bytes[15:0];
    return resp;
  endfunction

  task automatic report_mismatch(string what);
    err_count++;
    if (err_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    alloc_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_resp.size() == 0) begin
        report_mismatch($sformatf("response %h with no request outstanding", out_tdata));
      end else begin
        want = expected_resp.pop_front();
        checked_count++;
        status_seen[int'(want.status)]++;
        if (out_tdata[2:0] !== want.status)
          report_mismatch($sformatf("status %0d, expected %s", out_tdata[2:0],
                                    want.status.name()));
        if (out_tdata[17:3] !== want.payload)
          report_mismatch($sformatf("payload offset %0d, expected %0d", out_tdata[17:3],
                                    want.payload));
        if (out_tdata[33:18] !== want.in_use)
          report_mismatch($sformatf("bytes in use %0d, expected %0d", out_tdata[33:18],
                                    want.in_use));
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with the valid still high, so back-to-back requests need no gap.
  task automatic send_request(op_t op, int unsigned req, int unsigned rel);
    alloc_resp_t resp;
    if (tx_idle) begin
      while ($urandom_range(99) < 12) begin
        in_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    in_tdata  = {{(IN_W-33){1'b0}}, rel[REL_W-1:0], req[REQ_W-1:0], op};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    resp = model_request(op, req[REQ_W-1:0], rel[REL_W-1:0]);
    expected_resp.push_back(resp);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic drain_responses();
    in_tvalid = 1'b0;
    while (expected_resp.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, int unsigned value);
    drain_responses();
    cfg_index = idx;
    cfg_data  = value[CFG_W-1:0];
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_HEAP_BYTES) cfg_heap = value & 32'hFFFF;
    else cfg_max_req = value & 32'hFFFF;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_before_init();
    send_request(OP_ALLOC, 8, 0);
    send_request(OP_FREE, 0, 8);
    send_request(OP_NONE, 0, 0);
    send_request(OP_FREE, 0, 0);
  endtask

  task automatic test_alloc_free_edges();
    send_request(OP_INIT, 0, 0);
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_ALLOC, 16'hFFFF, 0);
    send_request(OP_ALLOC, 32768, 0);
    send_request(OP_ALLOC, 32760, 0);
    send_request(OP_ALLOC, 8, 0);
    send_request(OP_FREE, 0, 8);
    send_request(OP_FREE, 0, 8);
    send_request(OP_FREE, 0, 4);
    send_request(OP_FREE, 0, 15'h7FFF);
    send_request(OP_FREE, 0, 0);
    // A 64-byte heap fragments quickly, which exercises the no-fit and
    // whole-block paths.
    write_register(REG_HEAP_BYTES, 64);
    send_request(OP_INIT, 0, 0);
    send_request(OP_ALLOC, 8, 0);
    send_request(OP_ALLOC, 8, 0);
    send_request(OP_FREE, 0, 8);
    send_request(OP_ALLOC, 32, 0);
    send_request(OP_ALLOC, 16, 0);
    send_request(OP_FREE, 0, 16);
    send_request(OP_FREE, 0, 72);
    send_request(OP_FREE, 0, 40);
    send_request(OP_FREE, 0, 24);
  endtask

  task automatic test_register_extremes();
    write_register(REG_HEAP_BYTES, 0);
    write_register(REG_MAX_REQUEST, 16'hFFFF);
    send_request(OP_INIT, 0, 0);
    send_request(OP_ALLOC, 8, 0);
    send_request(OP_ALLOC, 1, 0);
    // A new heap size only takes hold at the next initialize.
    write_register(REG_HEAP_BYTES, 16'hFFFF);
    send_request(OP_ALLOC, 8, 0);
    send_request(OP_INIT, 0, 0);
    send_request(OP_ALLOC, 16'hFFFF, 0);
    send_request(OP_ALLOC, 32760, 0);
    write_register(REG_HEAP_BYTES, 23);
    write_register(REG_MAX_REQUEST, 0);
    send_request(OP_INIT, 0, 0);
    send_request(OP_ALLOC, 1, 0);
    write_register(REG_MAX_REQUEST, 8);
    send_request(OP_ALLOC, 8, 0);
    send_request(OP_ALLOC, 9, 0);
    write_register(REG_HEAP_BYTES, 7);
    write_register(REG_MAX_REQUEST, 32768);
    send_request(OP_INIT, 0, 0);
    send_request(OP_ALLOC, 8, 0);
  endtask

  task automatic run_phase(int unsigned heap, int unsigned max_req, int unsigned size_cap,
                           bit idle, bit pause, int n_items);
    int unsigned pick;
    int unsigned sel;
    int unsigned req;
    int unsigned rel;
    write_register(REG_HEAP_BYTES, heap);
    write_register(REG_MAX_REQUEST, max_req);
    tx_idle = idle;
    rx_idle = idle;
    send_request(OP_INIT, $urandom(), $urandom());
    for (int i = 0; i < n_items; i++) begin
      if (pause && i == n_items / 2) drain_responses();
      pick = $urandom_range(99);
      if (pick < 45) begin
        sel = $urandom_range(99);
        if (sel < 4) req = 0;
        else if (sel < 9) req = $urandom_range(16'hFFFF);
        else if (sel < 70) req = $urandom_range(48, 1);
        else req = $urandom_range(size_cap, 1);
        send_request(OP_ALLOC, req, $urandom());
      end else if (pick < 92) begin
        if (live_payloads.size() != 0 && pick < 80) begin
          rel = live_payloads[$urandom_range(live_payloads.size() - 1)];
        end else begin
          case ($urandom_range(3))
            0: rel = 0;
            1: rel = $urandom();
            2: rel = $urandom_range(heap_span / HDR_BYTES) * HDR_BYTES;
            default: begin
              rel = (live_payloads.size() != 0) ? live_payloads[0] : HDR_BYTES;
              rel += $urandom_range(HDR_BYTES - 1, 1);
            end
          endcase
        end
        send_request(OP_FREE, $urandom(), rel);
      end else if (pick < 99) begin
        send_request(OP_NONE, $urandom(), $urandom());
      end else begin
        send_request(OP_INIT, $urandom(), $urandom());
      end
    end
  endtask

  task automatic test_random_traffic();
    run_phase(256, 16'hFFFF, 64, 1'b1, 1'b0, 110);
    run_phase(1024, 128, 200, 1'b0, 1'b0, 110);
    run_phase(2048, 16'hFFFF, 512, 1'b1, 1'b1, 160);
    run_phase(40, 32768, 24, 1'b1, 1'b0, 60);
    run_phase(32768, 4096, 4096, 1'b1, 1'b0, 50);
    run_phase(520, 64, 96, 1'b1, 1'b0, 110);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_HEAP_BYTES;
    cfg_data    = '0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    used_bytes  = 0;
    heap_span   = 0;
    heap_up     = 1'b0;
    cfg_heap    = HEAP_CFG_RESET;
    cfg_max_req = MAX_REQ_RESET;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_before_init();
    test_alloc_free_edges();
    test_register_extremes();
    test_random_traffic();

    drain_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d of %0d requests across %0d register writes: %0d ok, %0d zero,",
             checked_count, sent_count, cfg_writes, status_seen[ST_OK], status_seen[ST_ZERO]);
    $display("%0d over limit, %0d no fit, %0d not allocated, %0d before initialize.",
             status_seen[ST_LIMIT], status_seen[ST_NOFIT], status_seen[ST_NOTALLOC],
             status_seen[ST_NOINIT]);
    if (err_count == 0 && expected_resp.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
